// ===== src/mixed_radix_index_converter_defines.svh =====
// Assertion macros used by the index converter top level.
`ifndef MIXED_RADIX_INDEX_CONVERTER_DEFINES_SVH
`define MIXED_RADIX_INDEX_CONVERTER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define MRC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define MRC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MRC_ASSERT_IMP(lbl, ante, cons, msg)
`define MRC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/mrc_pkg.sv =====
// Types, constants and helpers of the mixed-radix index converter.
`default_nettype none
package mrc_pkg;
    localparam int MAX_DIMS = 4;
    localparam int FIELD_DIMS = 4;
    localparam int IDX_W = 32;
    localparam int CRD_W = 16;
    localparam int BITS_PER_STG = 4;
    localparam int STG_PER_DIM = IDX_W / BITS_PER_STG;
    localparam int NUM_STG = FIELD_DIMS * STG_PER_DIM;
    localparam int CAP_DIMS = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;

    typedef enum logic {
        OP_JOIN  = 1'b0,
        OP_SPLIT = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_NUM_DIMS = 3'd0,
        REG_SIZE_D0  = 3'd1,
        REG_SIZE_D1  = 3'd2,
        REG_SIZE_D2  = 3'd3,
        REG_SIZE_D3  = 3'd4
    } t_reg;

    typedef struct packed {
        logic [2:0]                        used;
        logic [FIELD_DIMS-1:0][CRD_W-1:0] size;
    } t_cfg;

    typedef struct packed {
        t_op                               op;
        logic [IDX_W-1:0]                  num;
        logic [CRD_W-1:0]                  rem;
        logic [IDX_W-1:0]                  acc;
        logic                              oor;
        logic [FIELD_DIMS-1:0][CRD_W-1:0] crd_in;
        logic [FIELD_DIMS-1:0][CRD_W-1:0] crd_out;
    } t_item;

    // Dimension count in use: zero counts as one, large values saturate.
    function automatic logic [2:0] used_dims(input logic [2:0] num);
        logic [2:0] n;
        n = num;
        if (n == 3'd0) begin
            n = 3'd1;
        end
        if (n > 3'(CAP_DIMS)) begin
            n = 3'(CAP_DIMS);
        end
        return n;
    endfunction
endpackage
`default_nettype wire

// ===== src/mrc_cfg.sv =====
// APB register file holding the dimension count and dimension sizes.
`default_nettype none
module mrc_cfg (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [4:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output mrc_pkg::t_cfg      o_cfg
);
    logic [2:0]                                          r_num_dims;
    logic [mrc_pkg::FIELD_DIMS-1:0][mrc_pkg::CRD_W-1:0] r_size;
    logic                                                wr_en;
    mrc_pkg::t_reg                                       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = mrc_pkg::t_reg'(paddr[4:2]);

    // Register writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= 3'd1;
            for (int d = 0; d < mrc_pkg::FIELD_DIMS; d++) begin
                r_size[d] <= mrc_pkg::CRD_W'(1);
            end
        end else if (wr_en) begin
            case (reg_idx)
                mrc_pkg::REG_NUM_DIMS: r_num_dims <= pwdata[2:0];
                mrc_pkg::REG_SIZE_D0:  r_size[0] <= pwdata[mrc_pkg::CRD_W-1:0];
                mrc_pkg::REG_SIZE_D1:  r_size[1] <= pwdata[mrc_pkg::CRD_W-1:0];
                mrc_pkg::REG_SIZE_D2:  r_size[2] <= pwdata[mrc_pkg::CRD_W-1:0];
                mrc_pkg::REG_SIZE_D3:  r_size[3] <= pwdata[mrc_pkg::CRD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (reg_idx)
            mrc_pkg::REG_NUM_DIMS: prdata = {29'd0, r_num_dims};
            mrc_pkg::REG_SIZE_D0:  prdata = {16'd0, r_size[0]};
            mrc_pkg::REG_SIZE_D1:  prdata = {16'd0, r_size[1]};
            mrc_pkg::REG_SIZE_D2:  prdata = {16'd0, r_size[2]};
            mrc_pkg::REG_SIZE_D3:  prdata = {16'd0, r_size[3]};
            default:               prdata = 32'd0;
        endcase
    end

    assign o_cfg.used = mrc_pkg::used_dims(r_num_dims);
    assign o_cfg.size = r_size;
endmodule
`default_nettype wire

// ===== src/mrc_stage.sv =====
// One pipeline stage: four restoring-division steps and, on the first
// stage of a dimension, one Horner multiply-add.
`default_nettype none
module mrc_stage (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  wire  [1:0]         i_dim,
    input  wire                i_first,
    input  wire                i_last,
    input  mrc_pkg::t_cfg      i_cfg,
    input  wire                i_vld,
    input  mrc_pkg::t_item     i_item,
    output logic               o_vld,
    output mrc_pkg::t_item     o_item
);
    logic                         r_vld;
    mrc_pkg::t_item               r_item;
    mrc_pkg::t_item               n_item;
    logic [1:0]                   hd;
    logic [47:0]                  prod;
    logic [mrc_pkg::CRD_W:0]      sh;
    logic [mrc_pkg::CRD_W-1:0]    dvs;

    assign hd  = 2'(mrc_pkg::FIELD_DIMS - 1) - i_dim;
    assign dvs = i_cfg.size[i_dim];

    always_comb begin
        n_item = i_item;
        prod   = '0;
        sh     = '0;
        // Horner step for the dimension counted down from the slowest.
        if (i_first) begin
            n_item.rem = '0;
            if ({1'b0, hd} < i_cfg.used) begin
                prod = i_item.acc * {16'd0, i_cfg.size[hd]};
                n_item.acc = prod[31:0] + {16'd0, i_item.crd_in[hd]};
            end
        end
        // Restoring division, one quotient bit per step. A zero divisor
        // yields an all-ones quotient and the dividend's low CRD_W bits as remainder.
        for (int b = 0; b < mrc_pkg::BITS_PER_STG; b++) begin
            sh = {n_item.rem, n_item.num[mrc_pkg::IDX_W-1]};
            n_item.num = {n_item.num[mrc_pkg::IDX_W-2:0], 1'b0};
            if (sh >= {1'b0, dvs}) begin
                sh = sh - {1'b0, dvs};
                n_item.num[0] = 1'b1;
            end
            n_item.rem = sh[mrc_pkg::CRD_W-1:0];
        end
        if (i_last) begin
            n_item.crd_out[i_dim] = n_item.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
endmodule
`default_nettype wire

// ===== src/mixed_radix_index_converter.sv =====
// Top level of the mixed-radix index converter.
// Converts up to four column-major coordinates to a linear index (tuser 0)
// or a linear index back to coordinates (tuser 1), with dimension 0 the
// fastest. The block takes one request every cycle unless the output stalls,
// and returns each result once it has passed every stage: the split runs a
// restoring divider at four quotient bits per stage, eight stages per
// dimension, and the Horner multiply-adds ride in the first stage of each group. A stall on the
// output freezes the whole pipeline; the last stage is the output register.
`default_nettype none
`include "mixed_radix_index_converter_defines.svh"
module mixed_radix_index_converter (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           s_axis_tvalid,
    output logic          s_axis_tready,
    // [31:0] linear_in, [47:32] coord_in0, [63:48] coord_in1,
    // [79:64] coord_in2, [95:80] coord_in3
    input  wire  [95:0]   s_axis_tdata,
    // [0] opcode
    input  wire  [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  wire           m_axis_tready,
    // [31:0] linear_out, [47:32] coord_out0, [63:48] coord_out1,
    // [79:64] coord_out2, [95:80] coord_out3
    output logic [95:0]   m_axis_tdata,
    // [0] out_of_range
    output logic [0:0]    m_axis_tuser,
    input  wire           psel,
    input  wire           penable,
    input  wire           pwrite,
    input  wire  [4:0]    paddr,
    input  wire  [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    localparam int NS = mrc_pkg::NUM_STG;
    localparam int FD = mrc_pkg::FIELD_DIMS;

    mrc_pkg::t_cfg    cfg;
    logic             pipe_en;
    logic [NS:0]      stg_vld;
    mrc_pkg::t_item   stg_item [NS+1];
    mrc_pkg::t_item   in_item;
    mrc_pkg::t_item   last_item;
    logic [FD-1:0][mrc_pkg::CRD_W-1:0] crd_res;
    logic             oor_in;

    mrc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The pipeline moves whenever the output register is free or drained.
    assign pipe_en       = !stg_vld[NS] || m_axis_tready;
    assign s_axis_tready = pipe_en;

    // Bound check of the used coordinates.
    always_comb begin
        oor_in = 1'b0;
        for (int d = 0; d < FD; d++) begin
            if (3'(d) < cfg.used &&
                s_axis_tdata[32+16*d +: 16] >= cfg.size[d]) begin
                oor_in = 1'b1;
            end
        end
    end

    // Request entering the first stage.
    always_comb begin
        in_item.op      = mrc_pkg::t_op'(s_axis_tuser[0]);
        in_item.num     = s_axis_tdata[31:0];
        in_item.rem     = '0;
        in_item.acc     = '0;
        in_item.oor     = oor_in;
        in_item.crd_out = '0;
        for (int d = 0; d < FD; d++) begin
            in_item.crd_in[d] = s_axis_tdata[32+16*d +: 16];
        end
    end

    assign stg_vld[0]  = s_axis_tvalid;
    assign stg_item[0] = in_item;

    for (genvar k = 0; k < NS; k++) begin : g_stg
        mrc_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_dim   (2'(k / mrc_pkg::STG_PER_DIM)),
            .i_first ((k % mrc_pkg::STG_PER_DIM) == 0),
            .i_last  ((k % mrc_pkg::STG_PER_DIM) == mrc_pkg::STG_PER_DIM - 1),
            .i_cfg   (cfg),
            .i_vld   (stg_vld[k]),
            .i_item  (stg_item[k]),
            .o_vld   (stg_vld[k+1]),
            .o_item  (stg_item[k+1])
        );
    end

    // Result formatting from the output register.
    assign last_item = stg_item[NS];
    always_comb begin
        for (int d = 0; d < FD; d++) begin
            crd_res[d] = (last_item.op == mrc_pkg::OP_SPLIT && 3'(d) < cfg.used)
                       ? last_item.crd_out[d] : '0;
        end
    end

    assign m_axis_tvalid = stg_vld[NS];
    assign m_axis_tdata[31:0] = (last_item.op == mrc_pkg::OP_JOIN && !last_item.oor)
                              ? last_item.acc : '0;
    assign m_axis_tdata[95:32] = crd_res;
    assign m_axis_tuser[0] = (last_item.op == mrc_pkg::OP_JOIN) && last_item.oor;

    // A split result never flags a range error or carries an index.
    `MRC_ASSERT_IMP(a_split_clean, m_axis_tvalid && last_item.op == mrc_pkg::OP_SPLIT, m_axis_tuser[0] == 1'b0 && m_axis_tdata[31:0] == 32'd0, "split result has index or flag")
    // A range error forces a zero index.
    `MRC_ASSERT_IMP(a_oor_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[31:0] == 32'd0, "range error with nonzero index")
    // A join result carries no coordinates.
    `MRC_ASSERT_IMP(a_join_crd, m_axis_tvalid && last_item.op == mrc_pkg::OP_JOIN, m_axis_tdata[95:32] == 64'd0, "join result has coordinates")
    // A frozen pipeline keeps every stage occupancy.
    `MRC_ASSERT_NXT(a_stall_hold, !pipe_en, stg_vld[NS:1] == $past(stg_vld[NS:1]), "stage valid changed during stall")
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for the mixed-radix index converter: directed and random requests.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    // Expected result of one request.
    typedef struct packed {
        logic [31:0]                                       linear;
        logic [mrc_pkg::FIELD_DIMS-1:0][mrc_pkg::CRD_W-1:0] coord;
        logic                                              oor;
    } t_index_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Shadow copy of the converter's registers.
    logic [2:0]   dims_reg;
    logic [15:0]  extent [mrc_pkg::FIELD_DIMS];

    t_index_result expected_q[$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    int           stall_mode = 0;

    mixed_radix_index_converter DUT (.*);

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicts the result of one request from the shadow registers.
    function automatic t_index_result convert_index(mrc_pkg::t_op op, logic [31:0] lin,
                                                    logic [mrc_pkg::FIELD_DIMS-1:0][15:0] crd);
        t_index_result r;
        int           n;
        logic [31:0]  acc;
        logic [31:0]  rest;
        r = '0;
        n = (dims_reg == 3'd0) ? 1 :
            ((dims_reg > 3'(mrc_pkg::CAP_DIMS)) ? mrc_pkg::CAP_DIMS : int'(dims_reg));
        if (op == mrc_pkg::OP_JOIN) begin
            for (int d = 0; d < n; d++) begin
                if (crd[d] >= extent[d]) r.oor = 1'b1;
            end
            if (!r.oor) begin
                acc = 32'(crd[n-1]);
                for (int d = n - 2; d >= 0; d--) begin
                    acc = acc * 32'(extent[d]) + 32'(crd[d]);
                end
                r.linear = acc;
            end
        end else begin
            rest = lin;
            for (int d = 0; d < n; d++) begin
                if (extent[d] == 16'd0) begin
                    r.coord[d] = rest[15:0];
                    rest = 32'hFFFF_FFFF;
                end else begin
                    r.coord[d] = 16'(rest % 32'(extent[d]));
                    rest = rest / 32'(extent[d]);
                end
            end
        end
        return r;
    endfunction

    // Writes one register through the APB port; the block must be idle.
    task automatic write_reg(mrc_pkg::t_reg idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == mrc_pkg::REG_NUM_DIMS) dims_reg = value[2:0];
        else extent[int'(idx) - 1] = value[15:0];
    endtask

    task automatic set_shape(logic [2:0] n, logic [15:0] s0, logic [15:0] s1,
                             logic [15:0] s2, logic [15:0] s3);
        write_reg(mrc_pkg::REG_NUM_DIMS, 32'(n));
        write_reg(mrc_pkg::REG_SIZE_D0, 32'(s0));
        write_reg(mrc_pkg::REG_SIZE_D1, 32'(s1));
        write_reg(mrc_pkg::REG_SIZE_D2, 32'(s2));
        write_reg(mrc_pkg::REG_SIZE_D3, 32'(s3));
    endtask

    // Stops sending, waits for all results, then for the pipeline latency.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    // Sends one request, with bursts and random gaps in between.
    task automatic send_request(mrc_pkg::t_op op, logic [31:0] lin,
                                logic [mrc_pkg::FIELD_DIMS-1:0][15:0] crd);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {crd, lin};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(convert_index(op, lin, crd));
    endtask

    function automatic logic [15:0] rand_coord(int d);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 16'($urandom);
        if (pick == 1 || extent[d] == 0) return extent[d];
        return 16'($urandom_range(0, int'(extent[d]) - 1));
    endfunction

    task automatic send_random(int count);
        logic [mrc_pkg::FIELD_DIMS-1:0][15:0] crd;
        logic [31:0] lin;
        for (int i = 0; i < count; i++) begin
            for (int d = 0; d < mrc_pkg::FIELD_DIMS; d++) crd[d] = rand_coord(d);
            lin = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 1000)) : $urandom;
            send_request($urandom_range(0, 1) ? mrc_pkg::OP_SPLIT : mrc_pkg::OP_JOIN,
                         lin, crd);
        end
    endtask

    // Directed extremes, bound violations and zero sizes.
    task automatic test_directed;
        set_shape(3'd4, 16'd3, 16'd5, 16'd7, 16'd11);
        send_request(mrc_pkg::OP_JOIN, 32'd0, '0);
        send_request(mrc_pkg::OP_JOIN, 32'hFFFF_FFFF, {16'd10, 16'd6, 16'd4, 16'd2});
        send_request(mrc_pkg::OP_JOIN, 32'd0, {16'd10, 16'd6, 16'd4, 16'd3});
        send_request(mrc_pkg::OP_JOIN, 32'd0, {16'd11, 16'd0, 16'd0, 16'd0});
        send_request(mrc_pkg::OP_SPLIT, 32'd1154, {4{16'hFFFF}});
        send_request(mrc_pkg::OP_SPLIT, 32'hFFFF_FFFF, '0);
        drain();
        set_shape(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(mrc_pkg::OP_JOIN, 32'd0, {4{16'hFFFE}});
        send_request(mrc_pkg::OP_JOIN, 32'd0, {4{16'hFFFF}});
        send_request(mrc_pkg::OP_SPLIT, 32'hFFFF_FFFF, '0);
        send_request(mrc_pkg::OP_SPLIT, 32'h8000_0001, '0);
        drain();
        // Zero size and an out-of-list dimension count.
        set_shape(3'd0, 16'd0, 16'd9, 16'd0, 16'd2);
        send_request(mrc_pkg::OP_JOIN, 32'd0, {16'd1, 16'd1, 16'd1, 16'd0});
        send_request(mrc_pkg::OP_SPLIT, 32'h1234_5678, '0);
        drain();
        write_reg(mrc_pkg::REG_NUM_DIMS, 32'd7);
        send_request(mrc_pkg::OP_SPLIT, 32'h1234_5678, '0);
        send_request(mrc_pkg::OP_JOIN, 32'd0, {16'd1, 16'd0, 16'd1, 16'd0});
        drain();
        write_reg(mrc_pkg::REG_NUM_DIMS, 32'd5);
        send_request(mrc_pkg::OP_SPLIT, 32'hDEAD_BEEF, '0);
        drain();
        set_shape(3'd2, 16'd1, 16'd1, 16'd1, 16'd1);
        send_request(mrc_pkg::OP_JOIN, 32'd0, {16'hFFFF, 16'hFFFF, 16'd0, 16'd0});
        send_request(mrc_pkg::OP_SPLIT, 32'hA5A5_5A5A, '0);
        drain();
    endtask

    // Random shapes, each followed by a batch of random requests.
    task automatic test_random_shapes;
        logic [15:0] s [mrc_pkg::FIELD_DIMS];
        for (int ph = 0; ph < 12; ph++) begin
            for (int d = 0; d < mrc_pkg::FIELD_DIMS; d++) begin
                case ($urandom_range(0, 5))
                    0: s[d] = 16'hFFFF;
                    1: s[d] = 16'd1;
                    2: s[d] = 16'($urandom);
                    3: s[d] = (ph == 5) ? 16'd0 : 16'd2;
                    default: s[d] = 16'($urandom_range(2, 40));
                endcase
            end
            set_shape(3'($urandom_range(0, 7)), s[0], s[1], s[2], s[3]);
            send_random(55);
            if (ph == 6) begin
                // Hold off until the pipeline is empty, then go on.
                drain();
            end
            send_random(5);
            drain();
        end
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge i_clk) begin
        t_index_result exp_r;
        t_index_result got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[31:0], m_axis_tdata[95:32], m_axis_tuser[0]};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result %h", got);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: linear exp %h got %h, coords exp %h got %h,",
                                      " oor exp %b got %b"},
                                     exp_r.linear, got.linear, exp_r.coord, got.coord,
                                     exp_r.oor, got.oor);
                    end
                end
            end
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        dims_reg      = 3'd1;
        for (int d = 0; d < mrc_pkg::FIELD_DIMS; d++) extent[d] = 16'd1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Reset values first: every size is one.
        send_random(5);
        drain();
        test_directed();
        test_random_shapes();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/mrc_pkg.sv
src/mrc_cfg.sv
src/mrc_stage.sv
src/mixed_radix_index_converter.sv
tb/sv/testbench.sv
